FILE: hw/rtl/u8sd_pkg.sv
// shared types and constants for the byte-serial utf-8 decoder
// no dependencies
package u8sd_pkg;

    localparam int unsigned CpW    = 31;
    localparam int unsigned PendW  = 3;
    localparam int unsigned QDepth = 3;
    localparam int unsigned QCntW  = 2;

    localparam logic [7:0]     BadLeadCode = 8'h3F;
    localparam logic [1:0]     ContTag     = 2'b10;
    localparam logic [PendW-1:0] PendNone  = '0;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           end_of_text;
        logic           last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_decoded;

endpackage

FILE: hw/rtl/u8sd_decode.sv
// combinational decode of one byte against the open sequence state
// depends on u8sd_pkg
module u8sd_decode (
    input  logic [7:0]                   i_byte,
    input  logic [u8sd_pkg::PendW-1:0]   i_pend,
    input  logic [u8sd_pkg::CpW-1:0]     i_acc,
    output u8sd_pkg::t_decoded           o_dec,
    output logic [u8sd_pkg::PendW-1:0]   o_pend,
    output logic [u8sd_pkg::CpW-1:0]     o_acc
);
    import u8sd_pkg::*;

    logic             s_emit;
    t_result          s_res;
    logic [PendW-1:0] s_pend;
    logic [CpW-1:0]   s_acc;
    logic [CpW-1:0]   cont_acc;
    logic [PendW-1:0] cont_pend;
    logic             is_cont;

    // start of a character: at most one result
    always_comb begin
        s_emit = 1'b0;
        s_res  = '0;
        s_pend = PendNone;
        s_acc  = '0;
        if (i_byte == 8'h00) begin
            s_emit            = 1'b1;
            s_res.end_of_text = 1'b1;
        end else if (i_byte[7] == 1'b0) begin
            s_emit           = 1'b1;
            s_res.code_point = {{(CpW-8){1'b0}}, i_byte};
        end else if ((i_byte & 8'hE0) == 8'hC0) begin
            s_acc  = {{(CpW-5){1'b0}}, i_byte[4:0]};
            s_pend = 3'd1;
        end else if ((i_byte & 8'hF0) == 8'hE0) begin
            s_acc  = {{(CpW-4){1'b0}}, i_byte[3:0]};
            s_pend = 3'd2;
        end else if ((i_byte & 8'hF8) == 8'hF0) begin
            s_acc  = {{(CpW-3){1'b0}}, i_byte[2:0]};
            s_pend = 3'd3;
        end else if ((i_byte & 8'hFC) == 8'hF8) begin
            s_acc  = {{(CpW-2){1'b0}}, i_byte[1:0]};
            s_pend = 3'd4;
        end else if ((i_byte & 8'hFE) == 8'hFC) begin
            s_acc  = {{(CpW-1){1'b0}}, i_byte[0]};
            s_pend = 3'd5;
        end else begin
            s_emit           = 1'b1;
            s_res.code_point = {{(CpW-8){1'b0}}, BadLeadCode};
        end
    end

    assign is_cont   = (i_byte[7:6] == ContTag);
    assign cont_acc  = {i_acc[CpW-7:0], i_byte[5:0]};
    assign cont_pend = i_pend - 3'd1;

    always_comb begin
        o_dec  = '0;
        o_pend = s_pend;
        o_acc  = s_acc;
        if (i_pend != PendNone && is_cont) begin
            o_pend = cont_pend;
            o_acc  = cont_acc;
            if (cont_pend == PendNone) begin
                o_dec.count           = 2'd1;
                o_dec.res0.code_point = cont_acc;
                o_dec.res0.last_of_run = 1'b1;
                o_acc                 = '0;
            end
        end else if (i_pend != PendNone) begin
            // cut short: partial value first, then the byte starts afresh
            o_dec.res0.code_point = i_acc;
            if (s_emit) begin
                o_dec.count            = 2'd2;
                o_dec.res1             = s_res;
                o_dec.res1.last_of_run = 1'b1;
            end else begin
                o_dec.count            = 2'd1;
                o_dec.res0.last_of_run = 1'b1;
            end
        end else if (s_emit) begin
            o_dec.count            = 2'd1;
            o_dec.res0             = s_res;
            o_dec.res0.last_of_run = 1'b1;
        end
    end

endmodule

FILE: hw/rtl/u8sd_outq.sv
// three-entry result queue, head always at entry zero
// depends on u8sd_pkg
module u8sd_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_push_n,
    input  u8sd_pkg::t_result             i_push0,
    input  u8sd_pkg::t_result             i_push1,
    input  logic                          i_pop,
    output logic [u8sd_pkg::QCntW-1:0]    o_count,
    output u8sd_pkg::t_result             o_head
);
    import u8sd_pkg::*;

    t_result          r_q [QDepth];
    t_result          n_q [QDepth];
    logic [QCntW-1:0] r_count;
    logic [QCntW-1:0] n_count;
    logic [QCntW-1:0] base;
    logic [QCntW-1:0] base1;

    assign base  = r_count - {1'b0, i_pop};
    assign base1 = base + 2'd1;

    always_comb begin
        n_q = r_q;
        if (i_pop) begin
            for (int i = 0; i < QDepth - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        if (i_push_n != 2'd0 && base < QCntW'(QDepth)) begin
            n_q[base] = i_push0;
        end
        if (i_push_n == 2'd2 && base1 < QCntW'(QDepth)) begin
            n_q[base1] = i_push1;
        end
        n_count = base + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_count = r_count;
    assign o_head  = r_q[0];

endmodule

FILE: hw/rtl/utf8_stream_decoder.sv
// byte-serial utf-8 decoder (1 to 6 byte lead forms), top level
// depends on u8sd_pkg, u8sd_decode, u8sd_outq
// path: input byte register, combinational decode, then the result queue
// throughput: one byte per cycle unless stalled; a byte yielding two results
//   is taken only when the three-entry result queue has room for both
// reset: synchronous active-low clears the input valid flag, the queue count
//   and the sequence state (no sequence open)
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [30:0] o_code_point,
    output logic        o_end_of_text,
    output logic        o_last_of_run
);
    import u8sd_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [PendW-1:0] r_pend;
    logic [PendW-1:0] n_pend;
    logic [CpW-1:0]   r_acc;
    logic [CpW-1:0]   n_acc;
    t_decoded         dec;
    t_result          head;
    logic [QCntW-1:0] q_count;
    logic             pop;
    logic             consume;
    logic             in_accept;
    logic [2:0]       free;
    logic [1:0]       push_n;

    u8sd_decode u_decode (
        .i_byte (r_in_byte),
        .i_pend (r_pend),
        .i_acc  (r_acc),
        .o_dec  (dec),
        .o_pend (n_pend),
        .o_acc  (n_acc)
    );

    assign pop       = o_out_valid && !i_out_stall;
    assign free      = 3'(QDepth) - {1'b0, q_count} + {2'b00, pop};
    assign consume   = r_in_valid && ({1'b0, dec.count} <= free);
    assign push_n    = consume ? dec.count : 2'd0;
    assign o_in_stall = r_in_valid && !consume;
    assign in_accept = i_in_valid && !o_in_stall;

    u8sd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_push0  (dec.res0),
        .i_push1  (dec.res1),
        .i_pop    (pop),
        .o_count  (q_count),
        .o_head   (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pend     <= PendNone;
            r_acc      <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_pend <= n_pend;
                r_acc  <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    assign o_out_valid   = (q_count != '0);
    assign o_code_point  = head.code_point;
    assign o_end_of_text = head.end_of_text;
    assign o_last_of_run = head.last_of_run;

endmodule
